// ===== sv/cau_pkg.sv =====
// Shared types and constants of the complex arithmetic unit.
`default_nettype none
package cau_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int OP_W   = 4;
  localparam int EXP_W  = 7;
  localparam int ST_W   = 2;
  localparam logic [EXP_W-1:0] MAX_POWER = EXP_W'(64);

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
  localparam logic [OP_W-1:0] OP_RSUB = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 4'd4;
  localparam logic [OP_W-1:0] OP_RDIV = 4'd5;
  localparam logic [OP_W-1:0] OP_SQR  = 4'd6;
  localparam logic [OP_W-1:0] OP_POW  = 4'd7;
  localparam logic [OP_W-1:0] OP_MAG  = 4'd8;

  // status codes
  localparam logic [ST_W-1:0] ST_OK  = 2'd0;
  localparam logic [ST_W-1:0] ST_SAT = 2'd1;
  localparam logic [ST_W-1:0] ST_DZ  = 2'd2;

  // simple-path result kinds
  localparam logic [2:0] SK_ADD  = 3'd0;
  localparam logic [2:0] SK_SUB  = 3'd1;
  localparam logic [2:0] SK_RSUB = 3'd2;
  localparam logic [2:0] SK_ZERO = 3'd3;
  localparam logic [2:0] SK_ONE  = 3'd4;
  localparam logic [2:0] SK_COPY = 3'd5;

  // multiplier operand selects
  localparam logic [1:0] MA_XR = 2'd0;
  localparam logic [1:0] MA_XI = 2'd1;
  localparam logic [1:0] MA_YR = 2'd2;
  localparam logic [1:0] MA_YI = 2'd3;
  localparam logic       MB_YR = 1'b0;
  localparam logic       MB_YI = 1'b1;

  // accumulator operations
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  typedef struct packed {
    logic       load;
    logic       load_swap;
    logic       load_aa;
    logic [1:0] ma_sel;
    logic       mb_sel;
    logic [1:0] acc_op;
    logic       wr_re;
    logic       wr_im;
    logic       wr_den;
    logic       set_dz;
    logic       x_from_res;
    logic       div_start;
    logic       div_step;
    logic       div_wr_re;
    logic       div_wr_im;
    logic       sqrt_start;
    logic       sqrt_step;
    logic       sqrt_wr;
    logic       simple;
    logic [2:0] simple_kind;
    logic       out_load;
  } cau_cmd_t;

  typedef struct packed {
    logic acc_zero;
  } cau_stat_t;

endpackage
`default_nettype wire

// ===== sv/cau_datapath.sv =====
// Datapath: operand registers, shared multiplier, accumulator, divider, root unit.
`default_nettype none
module cau_datapath
  import cau_pkg::*;
(
  input  wire logic                     clk,
  input  wire cau_cmd_t                 cmd,
  input  wire logic signed [DATA_W-1:0] a_real,
  input  wire logic signed [DATA_W-1:0] a_imag,
  input  wire logic signed [DATA_W-1:0] b_real,
  input  wire logic signed [DATA_W-1:0] b_imag,
  output cau_stat_t                     stat,
  output logic signed [DATA_W-1:0]      real_out,
  output logic signed [DATA_W-1:0]      imag_out,
  output logic [ST_W-1:0]               status
);

  localparam int PW = 2 * DATA_W;
  localparam int AW = PW + 2;
  localparam int QW = DATA_W + 1;
  localparam int SH = FRAC_W + 1;
  localparam logic signed [DATA_W-1:0] VMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VMIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] ONE  = DATA_W'(1) << FRAC_W;

  logic signed [DATA_W-1:0] xr_r, xi_r, yr_r, yi_r;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [PW-1:0]     prod_r;
  logic signed [AW-1:0]     acc_r, acc_sh, acc_abs, prod_ext;
  logic [PW-1:0]            den_r, mag;
  logic signed [DATA_W-1:0] res_re_r, res_im_r, acc_sat;
  logic                     acc_ovf, ovf_r, dz_r;

  // divider
  logic [PW-1:0]            rem_r;
  logic [QW-1:0]            dsh_r, q_r;
  logic                     dneg_r, dbig_r;
  logic [PW:0]              dtry;
  logic signed [QW+1:0]     dval;
  logic signed [DATA_W-1:0] dres;
  logic                     dovf;

  // square root
  logic [PW-1:0]            s_r, root_r, bit_r, rtry;

  // simple results
  logic signed [DATA_W:0]   sre, sim;
  logic signed [DATA_W-1:0] sre_v, sim_v;
  logic                     s_ovf;

  logic signed [DATA_W-1:0] out_re_r, out_im_r;
  logic [ST_W-1:0]          out_st_r;

  always_comb begin
    unique case (cmd.ma_sel)
      MA_XR:   mul_a = xr_r;
      MA_XI:   mul_a = xi_r;
      MA_YR:   mul_a = yr_r;
      default: mul_a = yi_r;
    endcase
    mul_b = (cmd.mb_sel == MB_YI) ? yi_r : yr_r;
  end

  assign prod_ext = {{2{prod_r[PW-1]}}, prod_r};
  assign acc_sh   = acc_r >>> FRAC_W;
  assign acc_ovf  = (|acc_sh[AW-1:DATA_W-1]) && !(&acc_sh[AW-1:DATA_W-1]);
  assign acc_sat  = acc_ovf ? (acc_sh[AW-1] ? VMIN : VMAX) : acc_sh[DATA_W-1:0];
  assign acc_abs  = acc_r[AW-1] ? -acc_r : acc_r;
  assign mag      = acc_abs[PW-1:0];
  assign stat.acc_zero = (acc_r == '0);

  assign dtry = {rem_r, dsh_r[QW-1]};
  assign dval = dneg_r ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});
  always_comb begin
    if (dbig_r) begin
      dres = dneg_r ? VMIN : VMAX;
      dovf = 1'b1;
    end else if ((|dval[QW+1:DATA_W-1]) && !(&dval[QW+1:DATA_W-1])) begin
      dres = dval[QW+1] ? VMIN : VMAX;
      dovf = 1'b1;
    end else begin
      dres = dval[DATA_W-1:0];
      dovf = 1'b0;
    end
  end

  assign rtry = root_r + bit_r;

  always_comb begin
    sre = '0;
    sim = '0;
    case (cmd.simple_kind)
      SK_ADD: begin
        sre = {xr_r[DATA_W-1], xr_r} + {yr_r[DATA_W-1], yr_r};
        sim = {xi_r[DATA_W-1], xi_r} + {yi_r[DATA_W-1], yi_r};
      end
      SK_SUB: begin
        sre = {xr_r[DATA_W-1], xr_r} - {yr_r[DATA_W-1], yr_r};
        sim = {xi_r[DATA_W-1], xi_r} - {yi_r[DATA_W-1], yi_r};
      end
      SK_RSUB: begin
        sre = {yr_r[DATA_W-1], yr_r} - {xr_r[DATA_W-1], xr_r};
        sim = {yi_r[DATA_W-1], yi_r} - {xi_r[DATA_W-1], xi_r};
      end
      SK_ONE:  sre = {ONE[DATA_W-1], ONE};
      SK_COPY: begin
        sre = {xr_r[DATA_W-1], xr_r};
        sim = {xi_r[DATA_W-1], xi_r};
      end
      default: ;
    endcase
    sre_v = (sre[DATA_W] != sre[DATA_W-1]) ? (sre[DATA_W] ? VMIN : VMAX) : sre[DATA_W-1:0];
    sim_v = (sim[DATA_W] != sim[DATA_W-1]) ? (sim[DATA_W] ? VMIN : VMAX) : sim[DATA_W-1:0];
    s_ovf = (sre[DATA_W] != sre[DATA_W-1]) || (sim[DATA_W] != sim[DATA_W-1]);
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;

    if (cmd.load) begin
      xr_r  <= cmd.load_swap ? b_real : a_real;
      xi_r  <= cmd.load_swap ? b_imag : a_imag;
      yr_r  <= (cmd.load_swap || cmd.load_aa) ? a_real : b_real;
      yi_r  <= (cmd.load_swap || cmd.load_aa) ? a_imag : b_imag;
      ovf_r <= 1'b0;
      dz_r  <= 1'b0;
    end
    if (cmd.x_from_res) begin
      xr_r <= res_re_r;
      xi_r <= res_im_r;
    end

    case (cmd.acc_op)
      ACC_LOAD: acc_r <= prod_ext;
      ACC_ADD:  acc_r <= acc_r + prod_ext;
      ACC_SUB:  acc_r <= acc_r - prod_ext;
      default:  ;
    endcase

    if (cmd.wr_re) begin
      res_re_r <= acc_sat;
      if (acc_ovf) ovf_r <= 1'b1;
    end
    if (cmd.wr_im) begin
      res_im_r <= acc_sat;
      if (acc_ovf) ovf_r <= 1'b1;
    end
    if (cmd.wr_den) den_r <= acc_r[PW-1:0];
    if (cmd.set_dz) begin
      res_re_r <= VMAX;
      res_im_r <= VMAX;
      dz_r     <= 1'b1;
    end

    // restoring division: quotient floor(m * 2^FRAC / den), 33 bits
    if (cmd.div_start) begin
      dneg_r <= acc_r[AW-1];
      dbig_r <= ({{SH{1'b0}}, mag[PW-1:SH]} >= den_r);
      rem_r  <= {{SH{1'b0}}, mag[PW-1:SH]};
      dsh_r  <= {mag[SH-1:0], {FRAC_W{1'b0}}};
      q_r    <= '0;
    end
    if (cmd.div_step) begin
      dsh_r <= {dsh_r[QW-2:0], 1'b0};
      if (dtry >= {1'b0, den_r}) begin
        rem_r <= PW'(dtry - {1'b0, den_r});
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= dtry[PW-1:0];
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
    end
    if (cmd.div_wr_re) begin
      res_re_r <= dres;
      if (dovf) ovf_r <= 1'b1;
    end
    if (cmd.div_wr_im) begin
      res_im_r <= dres;
      if (dovf) ovf_r <= 1'b1;
    end

    // digit-by-digit square root, two radicand bits a step
    if (cmd.sqrt_start) begin
      s_r    <= acc_r[PW-1:0];
      root_r <= '0;
      bit_r  <= PW'(1) << (PW - 2);
    end
    if (cmd.sqrt_step) begin
      if (s_r >= rtry) begin
        s_r    <= s_r - rtry;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.sqrt_wr) begin
      res_im_r <= '0;
      if (|root_r[PW-1:DATA_W-1]) begin
        res_re_r <= VMAX;
        ovf_r    <= 1'b1;
      end else begin
        res_re_r <= root_r[DATA_W-1:0];
      end
    end

    if (cmd.simple) begin
      res_re_r <= sre_v;
      res_im_r <= sim_v;
      if (s_ovf) ovf_r <= 1'b1;
    end

    if (cmd.out_load) begin
      out_re_r <= res_re_r;
      out_im_r <= res_im_r;
      out_st_r <= dz_r ? ST_DZ : (ovf_r ? ST_SAT : ST_OK);
    end
  end

  assign real_out = out_re_r;
  assign imag_out = out_im_r;
  assign status   = out_st_r;

endmodule
`default_nettype wire

// ===== sv/cau_ctrl.sv =====
// Controller: sequences the datapath for each operation and owns the handshakes.
`default_nettype none
module cau_ctrl
  import cau_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [OP_W-1:0]  operation,
  input  wire logic [EXP_W-1:0] exponent,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire cau_stat_t        stat,
  output cau_cmd_t              cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SIMPLE = 4'd1;
  localparam logic [3:0] S_M1     = 4'd2;
  localparam logic [3:0] S_M2     = 4'd3;
  localparam logic [3:0] S_M3     = 4'd4;
  localparam logic [3:0] S_WB     = 4'd5;
  localparam logic [3:0] S_PNEXT  = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_DWB    = 4'd8;
  localparam logic [3:0] S_SQRT   = 4'd9;
  localparam logic [3:0] S_SWB    = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  // product pairs
  localparam logic [2:0] PH_RE  = 3'd0;
  localparam logic [2:0] PH_IM  = 3'd1;
  localparam logic [2:0] PH_DEN = 3'd2;
  localparam logic [2:0] PH_DRE = 3'd3;
  localparam logic [2:0] PH_DIM = 3'd4;

  localparam logic [5:0] DIV_LAST  = 6'd32;
  localparam logic [5:0] SQRT_LAST = 6'd31;

  logic [3:0]       state_r, state_nxt;
  logic [2:0]       ph_r, ph_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [EXP_W-1:0] pw_r, pw_nxt, e_cap;
  logic [2:0]       sk_r, sk_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [1:0]       ma1, ma2;
  logic             mb1, mb2, psub;

  assign e_cap = (exponent > MAX_POWER) ? MAX_POWER : exponent;

  always_comb begin
    unique case (ph_r)
      PH_RE:  begin ma1 = MA_XR; mb1 = MB_YR; ma2 = MA_XI; mb2 = MB_YI; psub = 1'b1; end
      PH_IM:  begin ma1 = MA_XR; mb1 = MB_YI; ma2 = MA_XI; mb2 = MB_YR; psub = 1'b0; end
      PH_DEN: begin ma1 = MA_YR; mb1 = MB_YR; ma2 = MA_YI; mb2 = MB_YI; psub = 1'b0; end
      PH_DRE: begin ma1 = MA_XR; mb1 = MB_YR; ma2 = MA_XI; mb2 = MB_YI; psub = 1'b0; end
      default: begin ma1 = MA_XI; mb1 = MB_YR; ma2 = MA_XR; mb2 = MB_YI; psub = 1'b1; end
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    pw_nxt    = pw_r;
    sk_nxt    = sk_r;
    cmd       = '0;
    cmd.ma_sel = ma1;
    cmd.mb_sel = mb1;
    cmd.acc_op = ACC_HOLD;
    cmd.simple_kind = sk_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          op_nxt   = operation;
          pw_nxt   = '0;
          state_nxt = S_M1;
          case (operation)
            OP_ADD:  begin sk_nxt = SK_ADD;  state_nxt = S_SIMPLE; end
            OP_SUB:  begin sk_nxt = SK_SUB;  state_nxt = S_SIMPLE; end
            OP_RSUB: begin sk_nxt = SK_RSUB; state_nxt = S_SIMPLE; end
            OP_MUL:  ph_nxt = PH_RE;
            OP_DIV:  ph_nxt = PH_DEN;
            OP_RDIV: begin cmd.load_swap = 1'b1; ph_nxt = PH_DEN; end
            OP_SQR:  begin cmd.load_aa = 1'b1; ph_nxt = PH_RE; end
            OP_POW: begin
              cmd.load_aa = 1'b1;
              ph_nxt = PH_RE;
              if (e_cap == '0) begin
                sk_nxt = SK_ONE;
                state_nxt = S_SIMPLE;
              end else if (e_cap == EXP_W'(1)) begin
                sk_nxt = SK_COPY;
                state_nxt = S_SIMPLE;
              end else begin
                pw_nxt = e_cap - EXP_W'(2);
              end
            end
            OP_MAG:  begin cmd.load_aa = 1'b1; ph_nxt = PH_DEN; end
            default: begin sk_nxt = SK_ZERO; state_nxt = S_SIMPLE; end
          endcase
        end
      end
      S_SIMPLE: begin
        cmd.simple = 1'b1;
        state_nxt  = S_FIN;
      end
      S_M1: state_nxt = S_M2;
      S_M2: begin
        cmd.acc_op = ACC_LOAD;
        cmd.ma_sel = ma2;
        cmd.mb_sel = mb2;
        state_nxt  = S_M3;
      end
      S_M3: begin
        cmd.acc_op = psub ? ACC_SUB : ACC_ADD;
        state_nxt  = S_WB;
      end
      S_WB: begin
        unique case (ph_r)
          PH_RE: begin
            cmd.wr_re = 1'b1;
            ph_nxt    = PH_IM;
            state_nxt = S_M1;
          end
          PH_IM: begin
            cmd.wr_im = 1'b1;
            state_nxt = (pw_r != '0) ? S_PNEXT : S_FIN;
          end
          PH_DEN: begin
            if (op_r == OP_MAG) begin
              cmd.sqrt_start = 1'b1;
              cnt_nxt   = '0;
              state_nxt = S_SQRT;
            end else if (stat.acc_zero) begin
              cmd.set_dz = 1'b1;
              state_nxt  = S_FIN;
            end else begin
              cmd.wr_den = 1'b1;
              ph_nxt     = PH_DRE;
              state_nxt  = S_M1;
            end
          end
          default: begin
            cmd.div_start = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_DIV;
          end
        endcase
      end
      S_PNEXT: begin
        cmd.x_from_res = 1'b1;
        pw_nxt    = pw_r - EXP_W'(1);
        ph_nxt    = PH_RE;
        state_nxt = S_M1;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_DWB;
        else cnt_nxt = cnt_r + 6'd1;
      end
      S_DWB: begin
        if (ph_r == PH_DRE) begin
          cmd.div_wr_re = 1'b1;
          ph_nxt    = PH_DIM;
          state_nxt = S_M1;
        end else begin
          cmd.div_wr_im = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == SQRT_LAST) state_nxt = S_SWB;
        else cnt_nxt = cnt_r + 6'd1;
      end
      S_SWB: begin
        cmd.sqrt_wr = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (!ovalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.out_load) ovalid_nxt = 1'b1;
    else if (out_tready) ovalid_nxt = 1'b0;
    else ovalid_nxt = ovalid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    ph_r  <= ph_nxt;
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    pw_r  <= pw_nxt;
    sk_r  <= sk_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/complex_arithmetic_unit_core.sv =====
// Top level of the complex arithmetic unit: ports, exponent register, assertions.
//
// Complex ALU on signed Q16.16 operands. One item on the in_ stream carries an
// operation code and operands a and b; one result (real, imaginary, status)
// leaves on the out_ stream for every item.
// cfg_wr_en / cfg_wr_data write the power exponent (reset value 1); write it
// only while the unit is idle.
// Each item runs through a controller sequence around one shared 32x32
// multiplier:
//   add, sub, reverse sub, power with exponent 0 or 1, unused codes: simple path
//   multiply, square: two product pairs
//   magnitude: one product pair, then 32 root steps
//   divide, reverse divide: three product pairs and two 33-step quotients; stops
//     after the first pair if the denominator is zero
//   power with exponent e >= 2: e-1 complex multiplies
// One item is worked on at a time; in_tready is high only when idle.
// The result sits in an output register, so the next item is accepted while
// it waits; a stalled receiver holds the unit only once the following result
// is also finished.
// Reset (rst_n low, synchronous) returns the controller to idle, drops
// out_tvalid and sets the exponent to 1.
`default_nettype none
module complex_arithmetic_unit_core
  import cau_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // operation[3:0], a_real[35:4], a_imag[67:36], b_real[99:68], b_imag[131:100]
  input  wire logic [135:0]     in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // real_out[31:0], imag_out[63:32], status[65:64]
  output logic [71:0]           out_tdata,
  input  wire logic             cfg_wr_en,
  input  wire logic [EXP_W-1:0] cfg_wr_data
);

  logic [EXP_W-1:0]         power_exponent_r;
  cau_cmd_t                 cmd;
  cau_stat_t                stat;
  logic signed [DATA_W-1:0] real_out, imag_out;
  logic [ST_W-1:0]          status;

  // hold the exponent between writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_exponent_r <= EXP_W'(1);
    end else if (cfg_wr_en) begin
      power_exponent_r <= cfg_wr_data;
    end
  end

  cau_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .operation  (in_tdata[3:0]),
    .exponent   (power_exponent_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // operands are captured on the accepting transfer
  cau_datapath u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .a_real   (in_tdata[35:4]),
    .a_imag   (in_tdata[67:36]),
    .b_real   (in_tdata[99:68]),
    .b_imag   (in_tdata[131:100]),
    .stat     (stat),
    .real_out (real_out),
    .imag_out (imag_out),
    .status   (status)
  );

  assign out_tdata = {6'b0, status, imag_out, real_out};

  // busy after every accepted transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again without finishing");

  // a division-by-zero result is saturated high in both parts
  a_dz_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[65:64] == ST_DZ |->
      out_tdata[31:0] == 32'h7fffffff && out_tdata[63:32] == 32'h7fffffff)
    else $error("divide-by-zero result not saturated");

  // no status code beyond divide-by-zero
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[65:64] == ST_OK || out_tdata[65:64] == ST_SAT ||
      out_tdata[65:64] == ST_DZ)
    else $error("bad status code");

endmodule
`default_nettype wire

// ===== tb/complex_arithmetic_unit_core_test.sv =====
// Self-checking testbench for the complex arithmetic unit core.
`timescale 1ns / 100ps
module complex_arithmetic_unit_core_test;
  import cau_pkg::*;

  typedef logic signed [99:0] wide_t;
  typedef logic signed [DATA_W-1:0] fix_t;

  typedef struct packed {
    fix_t            re;
    fix_t            im;
    logic [ST_W-1:0] st;
  } cplx_result_t;

  // highest operation code; codes above OP_MAG give a zero result
  localparam logic [OP_W-1:0] OP_LAST_CODE = 4'd15;
  localparam fix_t FIX_MAX = 32'sh7fffffff;
  localparam fix_t FIX_MIN = 32'sh80000000;
  localparam fix_t FIX_ONE = 32'sh00010000;

  // Scoreboard: predicts each accepted item, holds expected results in order
  class cplx_scoreboard;
    logic [EXP_W-1:0] exponent;
    cplx_result_t     pending[$];
    int               errors;

    function new();
      exponent = EXP_W'(1);
      errors = 0;
    endfunction

    // saturate to the data width; flag any clipping
    function fix_t clamp(wide_t v, inout bit ovf);
      if (v > wide_t'(FIX_MAX)) begin
        ovf = 1'b1;
        return FIX_MAX;
      end
      if (v < wide_t'(FIX_MIN)) begin
        ovf = 1'b1;
        return FIX_MIN;
      end
      return fix_t'(v);
    endfunction

    // product sums are exact; arithmetic shift floors them
    function void cmul(fix_t ar, fix_t ai, fix_t br, fix_t bi,
                       output fix_t re, output fix_t im, inout bit ovf);
      re = clamp((wide_t'(ar) * wide_t'(br) - wide_t'(ai) * wide_t'(bi)) >>> FRAC_W, ovf);
      im = clamp((wide_t'(ar) * wide_t'(bi) + wide_t'(br) * wide_t'(ai)) >>> FRAC_W, ovf);
    endfunction

    // quotient truncated toward zero to the fraction width
    function wide_t trunc_div(wide_t num, wide_t den);
      wide_t m;
      wide_t q;
      m = (num < 0) ? -num : num;
      q = (m <<< FRAC_W) / den;
      return (num < 0) ? -q : q;
    endfunction

    function void cdiv(fix_t nr, fix_t ni, fix_t dr, fix_t di, output fix_t re,
                       output fix_t im, inout bit ovf, inout bit dz);
      wide_t den;
      den = wide_t'(dr) * wide_t'(dr) + wide_t'(di) * wide_t'(di);
      if (den == 0) begin
        dz = 1'b1;
        re = FIX_MAX;
        im = FIX_MAX;
        return;
      end
      re = clamp(trunc_div(wide_t'(nr) * wide_t'(dr) + wide_t'(ni) * wide_t'(di), den), ovf);
      im = clamp(trunc_div(wide_t'(ni) * wide_t'(dr) - wide_t'(nr) * wide_t'(di), den), ovf);
    endfunction

    function wide_t floor_sqrt(wide_t s);
      wide_t r;
      wide_t t;
      r = 0;
      for (int b = 32; b >= 0; b--) begin
        t = r | (wide_t'(1) <<< b);
        if (t * t <= s) r = t;
      end
      return r;
    endfunction

    function cplx_result_t compute(logic [OP_W-1:0] op, fix_t ar, fix_t ai, fix_t br,
                                   fix_t bi);
      cplx_result_t res;
      bit           ovf;
      bit           dz;
      fix_t         tr;
      fix_t         ti;
      int           e;
      ovf = 1'b0;
      dz = 1'b0;
      res.re = '0;
      res.im = '0;
      case (op)
        OP_ADD: begin
          res.re = clamp(wide_t'(ar) + wide_t'(br), ovf);
          res.im = clamp(wide_t'(ai) + wide_t'(bi), ovf);
        end
        OP_SUB: begin
          res.re = clamp(wide_t'(ar) - wide_t'(br), ovf);
          res.im = clamp(wide_t'(ai) - wide_t'(bi), ovf);
        end
        OP_RSUB: begin
          res.re = clamp(wide_t'(br) - wide_t'(ar), ovf);
          res.im = clamp(wide_t'(bi) - wide_t'(ai), ovf);
        end
        OP_MUL:  cmul(ar, ai, br, bi, res.re, res.im, ovf);
        OP_DIV:  cdiv(ar, ai, br, bi, res.re, res.im, ovf, dz);
        OP_RDIV: cdiv(br, bi, ar, ai, res.re, res.im, ovf, dz);
        OP_SQR:  cmul(ar, ai, ar, ai, res.re, res.im, ovf);
        OP_POW: begin
          e = (exponent > MAX_POWER) ? int'(MAX_POWER) : int'(exponent);
          if (e == 0) begin
            res.re = FIX_ONE;
          end else if (e == 1) begin
            res.re = ar;
            res.im = ai;
          end else begin
            cmul(ar, ai, ar, ai, res.re, res.im, ovf);
            for (int k = 2; k < e; k++) begin
              cmul(res.re, res.im, ar, ai, tr, ti, ovf);
              res.re = tr;
              res.im = ti;
            end
          end
        end
        OP_MAG: begin
          res.re = clamp(floor_sqrt(wide_t'(ar) * wide_t'(ar) + wide_t'(ai) * wide_t'(ai)),
                         ovf);
        end
        default: ;
      endcase
      res.st = dz ? ST_DZ : (ovf ? ST_SAT : ST_OK);
      return res;
    endfunction

    // note an accepted input transfer
    function void note_input(logic [135:0] data);
      pending.push_back(compute(data[3:0], data[35:4], data[67:36], data[99:68],
                                data[131:100]));
    endfunction

    // check an accepted result transfer against the oldest prediction
    function void check_result(logic [71:0] data);
      cplx_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result %h", data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (data[31:0] !== want.re) begin
        $error("real_out: expected %h, got %h", want.re, data[31:0]);
        errors++;
      end
      if (data[63:32] !== want.im) begin
        $error("imag_out: expected %h, got %h", want.im, data[63:32]);
        errors++;
      end
      if (data[65:64] !== want.st) begin
        $error("status: expected %0d, got %0d", want.st, data[65:64]);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [135:0]         in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [71:0]          out_tdata;
  logic                 cfg_wr_en;
  logic [EXP_W-1:0]     cfg_wr_data;

  cplx_scoreboard sb;
  int             burst_left;

  complex_arithmetic_unit_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // operation, a_real, a_imag, b_real, b_imag
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // real_out, imag_out, status
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop: far beyond the slowest correct run (every item a 64th power,
  // every result waiting out the longest stall)
  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: check each result transfer, then pick tready for the next edge.
  // The stall density is redrawn at regular intervals, with some stretches
  // fully open; one long hold-off lets the unit fill up and stall its input.
  initial begin : receiver
    int cyc;
    int stall_pct;
    cyc = 0;
    stall_pct = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
      cyc++;
      if (cyc % 300 == 0) stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 90);
      if (cyc >= 4000 && cyc < 4600) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(1, 100) > stall_pct);
      end
    end
  end

  // Offer one item and hold it until the transfer; drop valid only for a gap
  // between bursts so that valid is never lowered and raised in one step.
  task automatic send_item(logic [OP_W-1:0] op, fix_t ar, fix_t ai, fix_t br, fix_t bi);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, bi, br, ai, ar, op};
    do @(posedge clk); while (!in_tready);
    sb.note_input({4'b0, bi, br, ai, ar, op});
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the sender until every expected result has arrived, then let the
  // unit settle for its longest latency
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic set_exponent(logic [EXP_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.exponent = value;
  endtask

  // Operand mix: full-range words, small and near-unity values so that
  // products and powers stay in range, and the extreme codes
  function automatic fix_t pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2: return fix_t'($urandom);
      3, 4:    return fix_t'($urandom_range(0, 2 * 65536 * 4)) - 4 * 65536;
      5, 6:    return fix_t'($urandom_range(0, 65536)) - 32768;
      7:       return FIX_ONE + fix_t'($urandom_range(0, 4096)) - 2048;
      8:       return fix_t'($urandom_range(0, 2 * 65536 * 256)) - 256 * 65536;
      default: begin
        case ($urandom_range(0, 3))
          0:       return FIX_MAX;
          1:       return FIX_MIN;
          2:       return '0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    if ($urandom_range(0, 24) == 0) return OP_W'($urandom_range(9, 15));
    return OP_W'($urandom_range(OP_ADD, OP_MAG));
  endfunction

  initial begin : stimulus
    logic [EXP_W-1:0] exps[7];
    logic [OP_W-1:0]  op;
    fix_t             a_re;
    fix_t             a_im;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    burst_left = 0;
    exps = '{EXP_W'(0), EXP_W'(2), EXP_W'(3), EXP_W'(64), EXP_W'(127), EXP_W'(9), EXP_W'(1)};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every operation, zero denominators, unused codes,
    // power at the reset exponent
    send_item(OP_ADD, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN);
    send_item(OP_ADD, FIX_MAX, FIX_MIN, FIX_MIN, FIX_MAX);
    send_item(OP_SUB, FIX_MIN, FIX_MAX, FIX_MAX, FIX_MIN);
    send_item(OP_RSUB, FIX_MIN, 32'sd5, FIX_MAX, -32'sd7);
    send_item(OP_MUL, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX);
    send_item(OP_MUL, FIX_ONE, -FIX_ONE, 32'sh00018000, 32'sh00004000);
    send_item(OP_MUL, -32'sd1, 32'sd1, 32'sd1, 32'sd3);
    send_item(OP_DIV, FIX_ONE, FIX_ONE, '0, '0);
    send_item(OP_DIV, FIX_MAX, FIX_MIN, 32'sd1, '0);
    send_item(OP_DIV, -FIX_ONE, 32'sd3, 32'sh00030000, -32'sh00010000);
    send_item(OP_DIV, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN);
    send_item(OP_RDIV, '0, '0, FIX_ONE, FIX_ONE);
    send_item(OP_RDIV, 32'sh00020000, 32'sh00010000, -FIX_ONE, 32'sd9);
    send_item(OP_SQR, FIX_MIN, FIX_MIN, '0, '0);
    send_item(OP_SQR, -32'sh00008000, 32'sh00010001, '0, '0);
    send_item(OP_POW, FIX_MIN, 32'sd11, '0, '0);
    send_item(OP_MAG, FIX_MIN, FIX_MIN, '0, '0);
    send_item(OP_MAG, FIX_MAX, '0, '0, '0);
    send_item(OP_MAG, 32'sh00030000, -32'sh00040000, '0, '0);
    send_item(OP_MAG, '0, '0, '0, '0);
    send_item(OP_LAST_CODE, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX);
    send_item(OP_MAG + 4'd1, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN);
    drain();

    // Random phases, one per exponent setting, extremes among them
    foreach (exps[p]) begin
      set_exponent(exps[p]);
      for (int n = 0; n < 180; n++) begin
        op = pick_op();
        a_re = pick_operand();
        a_im = pick_operand();
        // deep powers mostly on operands near the unit circle
        if (op == OP_POW && exps[p] > 3 && $urandom_range(0, 3) != 0) begin
          a_re = fix_t'($urandom_range(0, 2 * 70000)) - 70000;
          a_im = fix_t'($urandom_range(0, 2 * 20000)) - 20000;
        end
        send_item(op, a_re, a_im, pick_operand(), pick_operand());
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
